/* src/chgw_pkg.sv */
// shared constants and types of the gift-wrapping convex hull block
package chgw_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int IDX_BITS       = 6;
  localparam int QUEUE_DEPTH    = 2;

  typedef struct packed {
    logic busy;
    logic done;
  } back_status_t;

endpackage

/* src/chgw_if.sv */
// point and hull vertex channel interfaces
interface chgw_pt_if #(
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         final_point;

  modport source (output valid, output x_coord, output y_coord, output final_point,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input final_point,
                output ready);
endinterface

interface chgw_hull_if #(
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [chgw_pkg::IDX_BITS-1:0]     hull_index;
  logic signed [COORD_BITS-1:0]      hull_x;
  logic signed [COORD_BITS-1:0]      hull_y;
  logic                              end_of_hull;
  logic                              overflow_error;

  modport source (output valid, output hull_index, output hull_x, output hull_y,
                  output end_of_hull, output overflow_error, input ready);
  modport sink (input valid, input hull_index, input hull_x, input hull_y,
                input end_of_hull, input overflow_error, output ready);
endinterface

/* src/chgw_front.sv */
// front end: point load, store write, start vertex tracking, job issue
module chgw_front #(
  parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  chgw_pt_if.sink                                pt_i,
  input  chgw_pkg::back_status_t                 status_i,
  input  logic                                   q_full_i,
  output logic                                   wr_en_o,
  output logic [$clog2(MAX_POINTS)-1:0]          wr_addr_o,
  output logic signed [COORD_BITS-1:0]           wr_x_o,
  output logic signed [COORD_BITS-1:0]           wr_y_o,
  output logic                                   push_o,
  output logic [$clog2(MAX_POINTS+1)+$clog2(MAX_POINTS):0] job_o
);
  import chgw_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0]                count_q;
  logic [AW-1:0]                start_q;
  logic signed [COORD_BITS-1:0] max_x_q;
  logic                         drop_q;
  logic                         hold_q;

  logic          accept;
  logic          room;
  logic          new_max;
  logic [CW-1:0] n_next;
  logic [AW-1:0] start_next;
  logic          drop_next;

  assign pt_i.ready = !hold_q && !q_full_i;
  assign accept     = pt_i.valid && pt_i.ready;
  assign room       = count_q < CW'(MAX_POINTS);
  assign new_max    = (count_q == '0) || (pt_i.x_coord > max_x_q);
  assign n_next     = room ? count_q + 1'b1 : count_q;
  assign start_next = (room && new_max) ? count_q[AW-1:0] : start_q;
  assign drop_next  = drop_q || !room;

  assign wr_en_o   = accept && room;
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_x_o    = pt_i.x_coord;
  assign wr_y_o    = pt_i.y_coord;
  assign push_o    = accept && pt_i.final_point;
  assign job_o     = {n_next, start_next, drop_next};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      start_q <= '0;
      max_x_q <= '0;
      drop_q  <= 1'b0;
      hold_q  <= 1'b0;
    end else begin
      if (status_i.done) hold_q <= 1'b0;
      if (accept) begin
        if (pt_i.final_point) begin
          count_q <= '0;
          drop_q  <= 1'b0;
          hold_q  <= 1'b1;
        end else begin
          count_q <= n_next;
          start_q <= start_next;
          drop_q  <= drop_next;
        end
        if (room && new_max) max_x_q <= pt_i.x_coord;
      end
    end
  end

endmodule

/* src/chgw_queue.sv */
// short job queue between the load front end and the hull back end
module chgw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = chgw_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  import chgw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [NW-1:0]    level_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = level_q == NW'(DEPTH);
  assign empty_o = level_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) level_q <= level_q + 1'b1;
      else if (do_pop && !do_push) level_q <= level_q - 1'b1;
    end
  end

endmodule

/* src/chgw_back.sv */
// back end: point store, wrap scan with cross product and distance, vertex output
module chgw_back #(
  parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [$clog2(MAX_POINTS)-1:0]          wr_addr_i,
  input  logic signed [COORD_BITS-1:0]           wr_x_i,
  input  logic signed [COORD_BITS-1:0]           wr_y_i,
  input  logic [$clog2(MAX_POINTS+1)+$clog2(MAX_POINTS):0] job_i,
  input  logic                                   q_empty_i,
  output logic                                   q_pop_o,
  output chgw_pkg::back_status_t                 status_o,
  chgw_hull_if.source                            hull_o
);
  import chgw_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_MUL,
    ST_CMP,
    ST_FINISH,
    ST_EMIT
  } state_e;

  logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] rd_x_q;
  logic signed [COORD_BITS-1:0] rd_y_q;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;

  state_e                       state_q;
  logic [CW-1:0]                n_q;
  logic [AW-1:0]                start_q;
  logic                         drop_q;
  logic [AW-1:0]                cur_q;
  logic signed [COORD_BITS-1:0] cur_x_q;
  logic signed [COORD_BITS-1:0] cur_y_q;
  logic [AW-1:0]                cand_q;
  logic signed [COORD_BITS-1:0] cand_x_q;
  logic signed [COORD_BITS-1:0] cand_y_q;
  logic signed [XW-1:0]         cand_d2_q;
  logic                         have_q;
  logic [CW-1:0]                i_q;
  logic [CW-1:0]                k_q;
  logic                         end_q;
  logic                         cut_q;

  logic signed [PW-1:0]         p1_q;
  logic signed [PW-1:0]         p2_q;
  logic signed [PW-1:0]         dxx_q;
  logic signed [PW-1:0]         dyy_q;
  logic [AW-1:0]                pt_idx_q;
  logic signed [COORD_BITS-1:0] pt_x_q;
  logic signed [COORD_BITS-1:0] pt_y_q;

  logic                         out_valid_q;
  logic [AW-1:0]                out_idx_q;
  logic signed [COORD_BITS-1:0] out_x_q;
  logic signed [COORD_BITS-1:0] out_y_q;
  logic                         out_end_q;
  logic                         out_err_q;

  logic [CW-1:0]                job_n;
  logic [AW-1:0]                job_start;
  logic                         job_drop;
  logic signed [DW-1:0]         ax;
  logic signed [DW-1:0]         ay;
  logic signed [DW-1:0]         bx;
  logic signed [DW-1:0]         by;
  logic signed [PW-1:0]         p1;
  logic signed [PW-1:0]         p2;
  logic signed [PW-1:0]         dxx;
  logic signed [PW-1:0]         dyy;
  logic signed [XW-1:0]         turn;
  logic signed [XW-1:0]         d_pt;
  logic                         take;
  logic                         slot_free;
  logic                         scan_rd;

  assign {job_n, job_start, job_drop} = job_i;

  // point store
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      x_mem[wr_addr_i] <= wr_x_i;
      y_mem[wr_addr_i] <= wr_y_i;
    end
    if (rd_en) begin
      rd_x_q <= x_mem[rd_addr];
      rd_y_q <= y_mem[rd_addr];
    end
  end

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign scan_rd = (state_q == ST_SCAN) && (i_q != n_q) && (i_q[AW-1:0] != cur_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i_q[AW-1:0];
    if (q_pop_o) begin
      rd_en   = 1'b1;
      rd_addr = job_start;
    end else if (scan_rd) begin
      rd_en = 1'b1;
    end
  end

  // edge vectors from the current vertex
  assign ax  = {cand_x_q[COORD_BITS-1], cand_x_q} - {cur_x_q[COORD_BITS-1], cur_x_q};
  assign ay  = {cand_y_q[COORD_BITS-1], cand_y_q} - {cur_y_q[COORD_BITS-1], cur_y_q};
  assign bx  = {rd_x_q[COORD_BITS-1], rd_x_q} - {cur_x_q[COORD_BITS-1], cur_x_q};
  assign by  = {rd_y_q[COORD_BITS-1], rd_y_q} - {cur_y_q[COORD_BITS-1], cur_y_q};
  assign p1  = ax * by;
  assign p2  = ay * bx;
  assign dxx = bx * bx;
  assign dyy = by * by;

  assign turn = XW'(p1_q) - XW'(p2_q);
  assign d_pt = XW'(dxx_q) + XW'(dyy_q);
  assign take = !have_q
             || (!turn[XW-1] && (turn != '0))
             || ((turn == '0) && !(cand_d2_q > d_pt));

  assign slot_free = !out_valid_q || hull_o.ready;

  assign status_o.busy = state_q != ST_IDLE;
  assign status_o.done = (state_q == ST_EMIT) && slot_free && end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      start_q     <= '0;
      drop_q      <= 1'b0;
      cur_q       <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cand_q      <= '0;
      cand_x_q    <= '0;
      cand_y_q    <= '0;
      cand_d2_q   <= '0;
      have_q      <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      end_q       <= 1'b0;
      cut_q       <= 1'b0;
      p1_q        <= '0;
      p2_q        <= '0;
      dxx_q       <= '0;
      dyy_q       <= '0;
      pt_idx_q    <= '0;
      pt_x_q      <= '0;
      pt_y_q      <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_end_q   <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      if ((state_q == ST_EMIT) && slot_free) out_valid_q <= 1'b1;
      else if (hull_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            n_q     <= job_n;
            start_q <= job_start;
            drop_q  <= job_drop;
            state_q <= ST_START;
          end
        end
        ST_START: begin
          cur_q   <= start_q;
          cur_x_q <= rd_x_q;
          cur_y_q <= rd_y_q;
          k_q     <= CW'(1);
          i_q     <= '0;
          have_q  <= 1'b0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (i_q == n_q) state_q <= ST_FINISH;
          else if (i_q[AW-1:0] == cur_q) i_q <= i_q + 1'b1;
          else state_q <= ST_MUL;
        end
        ST_MUL: begin
          p1_q     <= p1;
          p2_q     <= p2;
          dxx_q    <= dxx;
          dyy_q    <= dyy;
          pt_idx_q <= i_q[AW-1:0];
          pt_x_q   <= rd_x_q;
          pt_y_q   <= rd_y_q;
          state_q  <= ST_CMP;
        end
        ST_CMP: begin
          if (take) begin
            cand_q    <= pt_idx_q;
            cand_x_q  <= pt_x_q;
            cand_y_q  <= pt_y_q;
            cand_d2_q <= d_pt;
            have_q    <= 1'b1;
          end
          i_q     <= i_q + 1'b1;
          state_q <= ST_SCAN;
        end
        ST_FINISH: begin
          if (!have_q || (cand_q == start_q)) begin
            end_q <= 1'b1;
            cut_q <= 1'b0;
          end else if (k_q >= n_q) begin
            end_q <= 1'b1;
            cut_q <= 1'b1;
          end else begin
            end_q <= 1'b0;
            cut_q <= 1'b0;
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_idx_q   <= cur_q;
            out_x_q     <= cur_x_q;
            out_y_q     <= cur_y_q;
            out_end_q   <= end_q;
            out_err_q   <= drop_q || cut_q;
            if (end_q) begin
              state_q <= ST_IDLE;
            end else begin
              cur_q   <= cand_q;
              cur_x_q <= cand_x_q;
              cur_y_q <= cand_y_q;
              k_q     <= k_q + 1'b1;
              i_q     <= '0;
              have_q  <= 1'b0;
              state_q <= ST_SCAN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // vertex output beat
  assign hull_o.valid          = out_valid_q;
  assign hull_o.hull_index     = IDX_BITS'(out_idx_q);
  assign hull_o.hull_x         = out_x_q;
  assign hull_o.hull_y         = out_y_q;
  assign hull_o.end_of_hull    = out_end_q;
  assign hull_o.overflow_error = out_err_q;

endmodule

/* src/convex_hull_gift_wrap.sv */
// top level of the gift-wrapping convex hull block
// Points enter one per cycle, unless the input is held off, and are written
// into an on-chip point store of MAX_POINTS entries; the beat with final_point
// set closes the set and hands a job to the hull engine through a two-entry
// queue. While the hull runs the point input is held off. For every hull
// vertex the engine walks all other stored points, skipping the current one,
// each through a store read, a multiply stage and a compare and update; it
// then ends the walk, decides whether the hull ends and emits the vertex,
// waiting in the emit step while the output register is stalled by the
// receiver. The store is not cleared after reset; it is only read at
// entries written during the current load. Vertices leave through an output
// register, start vertex first, with end_of_hull on the last one; points
// beyond MAX_POINTS are dropped and flagged in overflow_error, as is a wrap
// that runs longer than the point count.
module convex_hull_gift_wrap #(
  parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chgw_pt_if.sink     pt_i,
  chgw_hull_if.source hull_o
);
  import chgw_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int JW = CW + AW + 1;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [COORD_BITS-1:0] wr_x;
  logic signed [COORD_BITS-1:0] wr_y;
  logic                         q_push;
  logic [JW-1:0]                q_wdata;
  logic [JW-1:0]                q_rdata;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  back_status_t                 status;

  chgw_front #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pt_i      (pt_i),
    .status_i  (status),
    .q_full_i  (q_full),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_x_o    (wr_x),
    .wr_y_o    (wr_y),
    .push_o    (q_push),
    .job_o     (q_wdata)
  );

  chgw_queue #(
    .WIDTH(JW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  chgw_back #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_x_i    (wr_x),
    .wr_y_i    (wr_y),
    .job_i     (q_rdata),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .status_o  (status),
    .hull_o    (hull_o)
  );

`ifndef NO_ASSERTIONS
  // no point is loaded into the store while a hull is in progress
  a_hold_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !pt_i.ready)
    else $error("point input open while hull engine busy");

  // a queued job keeps the input closed
  a_hold_while_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty |-> !pt_i.ready)
    else $error("point input open with a job queued");

  // no job is pushed into a full queue
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job queue overrun");

  // the engine goes idle right after its last vertex
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |=> !status.busy)
    else $error("hull engine still busy after last vertex");
`endif

endmodule
